[rtl/mbeq_pkg.sv]
package mbeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int BTN_W    = 3;
    localparam int COORD_W  = 14;
    localparam int CODE_W   = 3;
    localparam int LOST_W   = 3;
    localparam int QCOUNT_W = 5;
    localparam int EDGE_W   = 2 * BTN_W;
    localparam int IDX_W    = $clog2(EDGE_W);
    localparam int ENTRY_W  = CODE_W + 2 * COORD_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    // raw word layout
    localparam int INVALID_BIT = 31;
    localparam int BTN_LSB     = 28;
    localparam int X_LSB       = 14;
    localparam int Y_LSB       = 0;

    localparam logic [COORD_W-1:0] RESET_POS = COORD_W'(100);

    // tuser codes
    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // event codes; down edges are EV_LDOWN + button, up edges follow
    localparam logic [CODE_W-1:0] EV_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] EV_LDOWN = 3'd1;

    typedef struct packed {
        logic take_in;   // latch the accepted beat
        logic push_step; // retire one pending edge event
        logic pop_read;  // read the oldest entry
        logic load_out;  // fill the output register
    } t_cmd;

    typedef struct packed {
        logic pend_empty;
    } t_sts;

endpackage

[rtl/mbeq_ctrl.sv]
module mbeq_ctrl
    import mbeq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_POP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.take_in = 1'b1;
                    n_state = (s_axis_tuser == ACT_POP) ? S_POP : S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.pend_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.push_step = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop_read = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/mbeq_dp.sv]
module mbeq_dp
    import mbeq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_word,
    input  logic                  i_action,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [BTN_W-1:0]   r_prev_btn;
    logic [COORD_W-1:0] r_cur_x, r_cur_y;
    logic [PTR_W-1:0]   r_rptr, r_wptr;
    logic [CNT_W-1:0]   r_count;
    logic [EDGE_W-1:0]  r_pend;
    logic [LOST_W-1:0]  r_lost;
    logic               r_is_pop;
    logic               r_have;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [BTN_W-1:0]   new_btn;
    logic [COORD_W-1:0] new_x, new_y;
    logic               word_ok;
    logic [IDX_W-1:0]   edge_idx;
    logic [CODE_W-1:0]  edge_code;
    logic               full;
    logic               do_write;
    logic               do_read;
    logic [CODE_W-1:0]  ev_code;
    logic [COORD_W-1:0] ev_x, ev_y;

    assign new_btn = i_word[BTN_LSB +: BTN_W];
    assign new_x   = i_word[X_LSB +: COORD_W];
    assign new_y   = i_word[Y_LSB +: COORD_W];
    assign word_ok = !i_word[INVALID_BIT];

    // lowest pending edge goes first
    always_comb begin
        edge_idx = '0;
        for (int i = EDGE_W - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                edge_idx = IDX_W'(i);
            end
        end
    end

    assign edge_code = EV_LDOWN + CODE_W'(edge_idx);
    assign full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign do_write  = i_cmd.push_step && !full;
    assign do_read   = i_cmd.pop_read && (r_count != '0);
    assign o_sts.pend_empty = (r_pend == '0);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[r_wptr] <= {edge_code, r_cur_x, r_cur_y};
        end
        if (do_read) begin
            r_rd_data <= mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn <= '0;
            r_cur_x    <= RESET_POS;
            r_cur_y    <= RESET_POS;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_count    <= '0;
            r_pend     <= '0;
            r_lost     <= '0;
            r_is_pop   <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            if (i_cmd.take_in) begin
                r_is_pop <= (i_action == ACT_POP);
                r_lost   <= '0;
                if (i_action == ACT_POLL && word_ok) begin
                    r_pend     <= {~new_btn & r_prev_btn, new_btn & ~r_prev_btn};
                    r_prev_btn <= new_btn;
                    r_cur_x    <= new_x;
                    r_cur_y    <= new_y;
                end else begin
                    r_pend <= '0;
                end
            end
            if (i_cmd.push_step) begin
                r_pend <= r_pend & (r_pend - EDGE_W'(1));
                if (full) begin
                    r_lost <= r_lost + LOST_W'(1);
                end else begin
                    r_wptr  <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.pop_read) begin
                r_have <= do_read;
                if (do_read) begin
                    r_rptr  <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        if (r_is_pop && r_have) begin
            ev_code = r_rd_data[2*COORD_W +: CODE_W];
            ev_x    = r_rd_data[COORD_W +: COORD_W];
            ev_y    = r_rd_data[0 +: COORD_W];
        end else begin
            ev_code = EV_NONE;
            ev_x    = '0;
            ev_y    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {2'b00, QCOUNT_W'(r_count), r_lost, ev_y, ev_x, ev_code,
                           r_cur_y, r_cur_x, r_prev_btn};
        end
    end

    assign o_data = r_out_data;

endmodule

[rtl/mouse_button_event_queue_top.sv]
// Mouse button event queue.
// Input beats arrive on s_axis: tdata carries the raw 32-bit mouse word, tuser
// selects the operation (0 poll with the word, 1 pop the oldest event).
// Each accepted beat yields exactly one result beat on m_axis, carrying the
// stored button/position status, the popped event (code and position, zero
// when none), the number of events dropped on a full queue, and the queue fill.
// One item is in flight at a time; s_axis_tready is high only while idle.
// A poll retires its button edge events (up to 3) one after another before the
// next accept; the edge events are written into the 16-entry queue memory one
// per cycle through its single write port.
// A pop goes through the registered memory read, the load of the output
// register and the return to idle.
// The result is loaded into the output register after the memory read (pop)
// or the last edge event (poll).
// If m_axis_tready is low, the result stays in the output register and the
// next item may still be accepted and worked; it then waits until the output
// register frees up before it is loaded.
// Reset (synchronous, active low) empties the queue and sets the status to no
// buttons at position 100,100; no clearing pass is needed.
module mouse_button_event_queue_top
    import mbeq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] raw_word
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] button_state, [16:3] pos_x, [30:17] pos_y, [33:31] event_code,
    // [47:34] event_x, [61:48] event_y, [64:62] dropped, [69:65] queue_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    mbeq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    mbeq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (s_axis_tdata),
        .i_action (s_axis_tuser),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_data   (m_axis_tdata)
    );

endmodule
